/* sv/rc4_pkg.sv */
// shared types and constants for the rc4 engine
// control word layout between the microcode sequencer and the datapath
`default_nettype none

package rc4_pkg;

  localparam int PERM_DEPTH = 256;
  localparam logic [8:0] KEY_LEN_RESET = 9'd16;

  typedef enum logic [1:0] {
    OP_KEY   = 2'd0,
    OP_START = 2'd1,
    OP_DATA  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // perm table read address source
  typedef enum logic [1:0] {
    RD_I  = 2'd0,
    RD_I1 = 2'd1,
    RD_JN = 2'd2,
    RD_T  = 2'd3
  } rd_sel_t;

  typedef enum logic [1:0] {
    J_HOLD   = 2'd0,
    J_ADD_S  = 2'd1,
    J_ADD_SK = 2'd2,
    J_CLR    = 2'd3
  } j_op_t;

  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_I_RD  = 2'd1,
    WR_J_SI  = 2'd2
  } wr_sel_t;

  typedef struct packed {
    logic    init;
    logic    rd_en;
    rd_sel_t rd_sel;
    j_op_t   j_op;
    logic    si_ld;
    logic    sj_ld;
    wr_sel_t wr_sel;
    logic    i_inc;
    logic    k_inc;
    logic    out_ld;
  } dp_ctrl_t;

  typedef struct packed {
    logic i_last;
    logic out_free;
  } seq_cond_t;

endpackage

`default_nettype wire

/* sv/rc4_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents when the same entry is written
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/rc4_seq.sv */
// microcode sequencer: step counter, control rom and conditional jumps
// depends on rc4_pkg for the control word and condition types
`default_nettype none

module rc4_seq
  import rc4_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start_ksa,
  input  logic      start_prga,
  input  seq_cond_t cond,
  output logic      busy,
  output dp_ctrl_t  ctrl
);

  typedef enum logic [3:0] {
    ST_KSA_INIT,
    ST_KSA_RD,
    ST_KSA_J,
    ST_KSA_W1,
    ST_KSA_W2,
    ST_KSA_END,
    ST_PRGA_RD,
    ST_PRGA_J,
    ST_PRGA_SW,
    ST_PRGA_OUT
  } step_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_LOOP,
    SEQ_WAIT,
    SEQ_DONE
  } seq_op_t;

  typedef struct packed {
    dp_ctrl_t dp;
    seq_op_t  seq;
    step_t    target;
  } row_t;

  step_t pc;
  logic  running;
  row_t  row;

  // control rom
  always_comb begin
    row = '0;
    row.seq = SEQ_NEXT;
    row.target = ST_KSA_RD;
    case (pc)
      ST_KSA_INIT: begin
        row.dp.init = 1'b1;
      end
      ST_KSA_RD: begin
        row.dp.rd_en = 1'b1;
        row.dp.rd_sel = RD_I;
      end
      ST_KSA_J: begin
        row.dp.rd_en = 1'b1;
        row.dp.rd_sel = RD_JN;
        row.dp.j_op = J_ADD_SK;
        row.dp.si_ld = 1'b1;
      end
      ST_KSA_W1: begin
        row.dp.wr_sel = WR_I_RD;
      end
      ST_KSA_W2: begin
        row.dp.wr_sel = WR_J_SI;
        row.dp.i_inc = 1'b1;
        row.dp.k_inc = 1'b1;
        row.seq = SEQ_LOOP;
        row.target = ST_KSA_RD;
      end
      ST_KSA_END: begin
        row.dp.j_op = J_CLR;
        row.seq = SEQ_DONE;
      end
      ST_PRGA_RD: begin
        row.dp.rd_en = 1'b1;
        row.dp.rd_sel = RD_I1;
        row.dp.i_inc = 1'b1;
      end
      ST_PRGA_J: begin
        row.dp.rd_en = 1'b1;
        row.dp.rd_sel = RD_JN;
        row.dp.j_op = J_ADD_S;
        row.dp.si_ld = 1'b1;
      end
      ST_PRGA_SW: begin
        row.dp.rd_en = 1'b1;
        row.dp.rd_sel = RD_T;
        row.dp.wr_sel = WR_I_RD;
        row.dp.sj_ld = 1'b1;
      end
      ST_PRGA_OUT: begin
        row.dp.wr_sel = WR_J_SI;
        row.dp.out_ld = 1'b1;
        row.seq = SEQ_WAIT;
      end
      default: begin
        row.seq = SEQ_DONE;
      end
    endcase
  end

  assign busy = running;
  assign ctrl = running ? row.dp : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      pc <= ST_KSA_INIT;
    end else if (!running) begin
      if (start_ksa) begin
        running <= 1'b1;
        pc <= ST_KSA_INIT;
      end else if (start_prga) begin
        running <= 1'b1;
        pc <= ST_PRGA_RD;
      end
    end else begin
      case (row.seq)
        SEQ_NEXT: begin
          pc <= step_t'(pc + 4'd1);
        end
        SEQ_LOOP: begin
          if (cond.i_last) begin
            pc <= step_t'(pc + 4'd1);
          end else begin
            pc <= row.target;
          end
        end
        SEQ_WAIT: begin
          if (cond.out_free) begin
            running <= 1'b0;
          end
        end
        SEQ_DONE: begin
          running <= 1'b0;
        end
        default: begin
          running <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/rc4_stream_cipher.sv */
// rc4 stream cipher top level: request decode, perm table and key store
// datapath, output register; uses rc4_pkg, rc4_ram and rc4_seq
//
// A key byte request (op 0) is written into the key store when accepted.
// A start request (op 1) runs the key schedule from a microcode program
// that drives one perm table ram port pair: one init step, four steps
// for each of the 256 table entries and one closing step; the block
// takes no new request until the closing step is done. A data
// request (op 2) runs four microcode steps (read S[i], read S[j], swap
// and read S[t], output) and takes no new request until they finish;
// the last step waits while an earlier result still sits unread in the
// output register. The perm table reads as identity after reset and at
// the start of every key schedule through a per-entry valid bit.
`default_nettype none

module rc4_stream_cipher
  import rc4_pkg::*;
#(
  parameter int KEY_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  logic [7:0] key_index,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] cfg_key_length
);

  localparam int KW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam logic [8:0] KEY_DEPTH_W = 9'(KEY_DEPTH);

  dp_ctrl_t  ctrl;
  seq_cond_t cond;
  logic      busy;
  logic      in_acc;
  op_t       op_in;

  logic [8:0] key_length;
  logic [8:0] len_eff;

  logic [7:0]    i_q;
  logic [7:0]    j_q;
  logic [7:0]    j_next;
  logic [KW-1:0] k_q;
  logic [KW-1:0] k_next;
  logic [8:0]    k_inc9;
  logic [7:0]    si;
  logic [7:0]    sj;
  logic [7:0]    t_q;
  logic [7:0]    data_q;

  logic [PERM_DEPTH-1:0] vld;
  logic       vld_q;
  logic [7:0] s_raddr;
  logic [7:0] s_raddr_q;
  logic [7:0] s_ram_rd;
  logic [7:0] s_rd;
  logic       s_we;
  logic [7:0] s_waddr;
  logic [7:0] s_wdata;

  logic       k_we;
  logic [7:0] k_rd;

  logic       out_free;
  logic [7:0] ks;

  assign op_in = op_t'(op);
  assign in_stall = busy;
  assign in_acc = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= KEY_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      key_length <= cfg_key_length;
    end
  end

  always_comb begin
    if (key_length == 9'd0) begin
      len_eff = 9'd1;
    end else if (key_length > KEY_DEPTH_W) begin
      len_eff = KEY_DEPTH_W;
    end else begin
      len_eff = key_length;
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign cond.i_last = (i_q == 8'hFF);
  assign cond.out_free = out_free;

  rc4_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start_ksa  (in_acc && op_in == OP_START),
    .start_prga (in_acc && op_in == OP_DATA),
    .cond       (cond),
    .busy       (busy),
    .ctrl       (ctrl)
  );

  // key store
  assign k_we = in_acc && op_in == OP_KEY && ({1'b0, key_index} < KEY_DEPTH_W);

  rc4_ram #(
    .WIDTH (8),
    .DEPTH (KEY_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (key_index[KW-1:0]),
    .wdata (in_byte),
    .re    (1'b1),
    .raddr (k_q),
    .rdata (k_rd)
  );

  // perm table, entries not yet written read as their own index
  assign s_rd = vld_q ? s_ram_rd : s_raddr_q;

  always_comb begin
    case (ctrl.j_op)
      J_HOLD:   j_next = j_q;
      J_ADD_S:  j_next = j_q + s_rd;
      J_ADD_SK: j_next = j_q + s_rd + k_rd;
      J_CLR:    j_next = 8'd0;
      default:  j_next = j_q;
    endcase
  end

  always_comb begin
    case (ctrl.rd_sel)
      RD_I:    s_raddr = i_q;
      RD_I1:   s_raddr = i_q + 8'd1;
      RD_JN:   s_raddr = j_next;
      RD_T:    s_raddr = si + s_rd;
      default: s_raddr = i_q;
    endcase
  end

  always_comb begin
    case (ctrl.wr_sel)
      WR_I_RD: begin
        s_we = 1'b1;
        s_waddr = i_q;
        s_wdata = s_rd;
      end
      WR_J_SI: begin
        s_we = 1'b1;
        s_waddr = j_q;
        s_wdata = si;
      end
      default: begin
        s_we = 1'b0;
        s_waddr = i_q;
        s_wdata = si;
      end
    endcase
  end

  rc4_ram #(
    .WIDTH (8),
    .DEPTH (PERM_DEPTH)
  ) u_perm_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (ctrl.rd_en),
    .raddr (s_raddr),
    .rdata (s_ram_rd)
  );

  // key counter wraps at the effective key length
  assign k_inc9 = {{(9 - KW){1'b0}}, k_q} + 9'd1;

  always_comb begin
    if (ctrl.init) begin
      k_next = '0;
    end else if (ctrl.k_inc) begin
      k_next = (k_inc9 >= len_eff) ? '0 : k_inc9[KW-1:0];
    end else begin
      k_next = k_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i_q <= 8'd0;
      j_q <= 8'd0;
      k_q <= '0;
      vld <= '0;
      vld_q <= 1'b0;
      s_raddr_q <= 8'd0;
    end else begin
      k_q <= k_next;
      if (ctrl.init) begin
        i_q <= 8'd0;
        j_q <= 8'd0;
        vld <= '0;
      end else begin
        if (ctrl.i_inc) begin
          i_q <= i_q + 8'd1;
        end
        j_q <= j_next;
        if (s_we) begin
          vld[s_waddr] <= 1'b1;
        end
      end
      if (ctrl.rd_en) begin
        vld_q <= vld[s_raddr];
        s_raddr_q <= s_raddr;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      data_q <= in_byte;
    end
    if (ctrl.si_ld) begin
      si <= s_rd;
    end
    if (ctrl.sj_ld) begin
      sj <= s_rd;
      t_q <= s_raddr;
    end
  end

  // the swap may have moved the entry at t
  always_comb begin
    if (t_q == i_q) begin
      ks = sj;
    end else if (t_q == j_q) begin
      ks = si;
    end else begin
      ks = s_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_ld && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_ld && out_free) begin
      out_byte <= data_q ^ ks;
    end
  end

`ifndef SYNTHESIS
  a_ksa_end_i_wrapped: assert property (@(posedge clk) disable iff (rst)
    ctrl.j_op == J_CLR |-> i_q == 8'd0)
    else $error("key schedule ended with i not wrapped to zero");

  a_out_from_ucode: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl.out_ld))
    else $error("result appeared without an output step");

  a_init_clears_table: assert property (@(posedge clk) disable iff (rst)
    ctrl.init |=> vld == '0)
    else $error("perm table valid bits not cleared by key schedule start");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !k_we)
    else $error("key store written while the sequencer runs");
`endif

endmodule

`default_nettype wire
